// File: hdl/sha1s_pkg.sv
package sha1s_pkg;

    // Chaining words as a packed vector, word 0 in the low bits.
    typedef logic [4:0][31:0] t_chain;

    // Initial hash values, word 0 is the most significant digest word.
    localparam t_chain H_INIT = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    // Round constants for the four groups of twenty rounds.
    localparam logic [31:0] K_0 = 32'h5A827999;
    localparam logic [31:0] K_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_3 = 32'hCA62C1D6;

    // Round group boundaries and the last round.
    localparam logic [6:0] ROUND_G1   = 7'd20;
    localparam logic [6:0] ROUND_G2   = 7'd40;
    localparam logic [6:0] ROUND_G3   = 7'd60;
    localparam logic [6:0] ROUND_LAST = 7'd79;

    // Padding constants.
    localparam logic [7:0] PAD_MARK  = 8'h80;
    localparam logic [7:0] PAD_ZERO  = 8'h00;
    localparam logic [5:0] LEN_POS   = 6'd56;
    localparam logic [5:0] FILL_LAST = 6'd63;

    // Digest word index of the final word.
    localparam logic [2:0] WORD_LAST = 3'd4;

    // Top level sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ROUND,
        S_FOLD,
        S_OUT
    } t_state;

    // Control to the message schedule line.
    typedef struct packed {
        logic       load;
        logic       expand;
        logic [7:0] data;
    } t_sched_ctl;

    // Control to the round unit.
    typedef struct packed {
        logic start;
        logic round;
        logic fold;
        logic init;
    } t_core_ctl;

    // Status from the round unit.
    typedef struct packed {
        logic rnd_last;
    } t_core_sts;

endpackage

// File: hdl/sha1s_sched.sv
module sha1s_sched (
    input  logic                  i_clk,
    input  sha1s_pkg::t_sched_ctl i_ctl,
    output logic [31:0]           o_w0
);
    import sha1s_pkg::*;

    logic [15:0][31:0] r_w;
    logic [15:0][31:0] n_w;
    logic [31:0]       w_mix;

    // New schedule word from the fixed taps of the line.
    assign w_mix = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];

    // The line shifts by one byte while the block fills and by one word per round.
    always_comb begin
        n_w = r_w;
        if (i_ctl.load) begin
            for (int i = 0; i < 15; i++) begin
                n_w[i] = {r_w[i][23:0], r_w[i+1][31:24]};
            end
            n_w[15] = {r_w[15][23:0], i_ctl.data};
        end else if (i_ctl.expand) begin
            for (int i = 0; i < 15; i++) begin
                n_w[i] = r_w[i+1];
            end
            n_w[15] = {w_mix[30:0], w_mix[31]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_w <= n_w;
    end

    assign o_w0 = r_w[0];

endmodule

// File: hdl/sha1s_core.sv
module sha1s_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sha1s_pkg::t_core_ctl i_ctl,
    input  logic [31:0]          i_w,
    output sha1s_pkg::t_core_sts o_sts,
    output sha1s_pkg::t_chain    o_chain
);
    import sha1s_pkg::*;

    t_chain      r_h, n_h;
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] n_a, n_b, n_c, n_d, n_e;
    logic [6:0]  r_rnd, n_rnd;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] t_val;

    // Round function and constant for the current group.
    always_comb begin
        if (r_rnd < ROUND_G1) begin
            f_val = (r_b & r_c) | (~r_b & r_d);
            k_val = K_0;
        end else if (r_rnd < ROUND_G2) begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = K_1;
        end else if (r_rnd < ROUND_G3) begin
            f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k_val = K_2;
        end else begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = K_3;
        end
    end

    assign t_val = {r_a[26:0], r_a[31:27]} + f_val + r_e + k_val + i_w;

    // Working variables, round counter and chaining words.
    always_comb begin
        n_a   = r_a;
        n_b   = r_b;
        n_c   = r_c;
        n_d   = r_d;
        n_e   = r_e;
        n_rnd = r_rnd;
        n_h   = r_h;
        if (i_ctl.start) begin
            n_a   = r_h[0];
            n_b   = r_h[1];
            n_c   = r_h[2];
            n_d   = r_h[3];
            n_e   = r_h[4];
            n_rnd = '0;
        end else if (i_ctl.round) begin
            n_a   = t_val;
            n_b   = r_a;
            n_c   = {r_b[1:0], r_b[31:2]};
            n_d   = r_c;
            n_e   = r_d;
            n_rnd = r_rnd + 7'd1;
        end
        if (i_ctl.fold) begin
            n_h[0] = r_h[0] + r_a;
            n_h[1] = r_h[1] + r_b;
            n_h[2] = r_h[2] + r_c;
            n_h[3] = r_h[3] + r_d;
            n_h[4] = r_h[4] + r_e;
        end else if (i_ctl.init) begin
            n_h = H_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h   <= H_INIT;
            r_rnd <= '0;
        end else begin
            r_h   <= n_h;
            r_rnd <= n_rnd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_b <= n_b;
        r_c <= n_c;
        r_d <= n_d;
        r_e <= n_e;
    end

    assign o_sts.rnd_last = (r_rnd == ROUND_LAST);
    assign o_chain        = r_h;

endmodule

// File: hdl/sha1_stream_hasher_top.sv
// SHA-1 over a byte stream. Each accepted item with i_byte_valid set adds one
// message byte. When 64 bytes are buffered the block runs the 80 rounds on a
// single round unit, one round per cycle, then adds the result into the
// chaining words in the fold state; o_in_stall is high through the rounds and
// the fold. An item with i_end_of_message set starts the padding: the pad and
// length bytes are written one per cycle, spilling into a second block when
// the length does not fit, each full block is compressed as above, and then
// the digest leaves as five output transfers, word 0 first, with o_last_word
// on the fifth. The block accepts no input until the last digest word is
// taken, and then starts the next message from the initial hash values.
module sha1_stream_hasher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_end_of_message,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import sha1s_pkg::*;

    t_state      r_state, n_state;
    logic [5:0]  r_fill, n_fill;
    logic [60:0] r_count, n_count;
    logic [63:0] r_len, n_len;
    logic        r_eom, n_eom;
    logic        r_mark, n_mark;
    logic        r_final, n_final;
    logic        r_last, n_last;
    logic [2:0]  r_idx, n_idx;

    t_sched_ctl  sched_ctl;
    t_core_ctl   core_ctl;
    t_core_sts   core_sts;
    t_chain      chain;
    logic [31:0] w0;

    sha1s_sched u_sched (
        .i_clk (i_clk),
        .i_ctl (sched_ctl),
        .o_w0  (w0)
    );

    sha1s_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (core_ctl),
        .i_w     (w0),
        .o_sts   (core_sts),
        .o_chain (chain)
    );

    // Sequencer: byte intake, padding, rounds, fold and digest output.
    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_count   = r_count;
        n_len     = r_len;
        n_eom     = r_eom;
        n_mark    = r_mark;
        n_final   = r_final;
        n_last    = r_last;
        n_idx     = r_idx;
        sched_ctl = '0;
        core_ctl  = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_byte_valid) begin
                        sched_ctl.load = 1'b1;
                        sched_ctl.data = i_data_byte;
                        n_fill         = r_fill + 6'd1;
                        n_count        = r_count + 61'd1;
                    end
                    if (i_end_of_message) begin
                        n_eom = 1'b1;
                        n_len = {r_count + {60'd0, i_byte_valid}, 3'b000};
                    end
                    if (i_byte_valid && (r_fill == FILL_LAST)) begin
                        core_ctl.start = 1'b1;
                        n_state        = S_ROUND;
                    end else if (i_end_of_message) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                // Mark byte, then zeros, then the bit length in the final block.
                sched_ctl.load = 1'b1;
                if (!r_mark) begin
                    sched_ctl.data = PAD_MARK;
                    n_mark         = 1'b1;
                    if (r_fill < LEN_POS) begin
                        n_final = 1'b1;
                    end
                end else if (r_final && (r_fill >= LEN_POS)) begin
                    sched_ctl.data = r_len[63:56];
                    n_len          = {r_len[55:0], 8'h00};
                end else begin
                    sched_ctl.data = PAD_ZERO;
                end
                n_fill = r_fill + 6'd1;
                if (r_fill == FILL_LAST) begin
                    core_ctl.start = 1'b1;
                    n_state        = S_ROUND;
                    if (r_final) begin
                        n_last = 1'b1;
                    end else begin
                        n_final = 1'b1;
                    end
                end
            end
            S_ROUND: begin
                core_ctl.round   = 1'b1;
                sched_ctl.expand = 1'b1;
                if (core_sts.rnd_last) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                core_ctl.fold = 1'b1;
                if (r_last) begin
                    n_state = S_OUT;
                end else if (r_eom) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    if (r_idx == WORD_LAST) begin
                        // Digest delivered: return to the initial state.
                        core_ctl.init = 1'b1;
                        n_fill        = '0;
                        n_count       = '0;
                        n_eom         = 1'b0;
                        n_mark        = 1'b0;
                        n_final       = 1'b0;
                        n_last        = 1'b0;
                        n_idx         = '0;
                        n_state       = S_IDLE;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_count <= '0;
            r_eom   <= 1'b0;
            r_mark  <= 1'b0;
            r_final <= 1'b0;
            r_last  <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_count <= n_count;
            r_eom   <= n_eom;
            r_mark  <= n_mark;
            r_final <= n_final;
            r_last  <= n_last;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len <= n_len;
    end

    // Handshake and result fields, all from registers.
    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = (r_state == S_OUT);
    assign o_digest_word = chain[r_idx];
    assign o_word_index  = r_idx;
    assign o_last_word   = (r_idx == WORD_LAST);

endmodule

// File: sim/tb_sha1_stream_hasher_top.sv
module tb_sha1_stream_hasher_top;

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles without any transfer before the run is declared hung. A worst case
    // pad of two blocks, two compressions and the longest stall fit well inside.
    localparam int unsigned IDLE_LIMIT   = 4000;
    localparam int unsigned DRAIN_CYCLES = 300;
    localparam int unsigned RANDOM_ITEMS = 480;
    localparam int unsigned MIN_MESSAGES = 15;
    localparam int unsigned MAX_REPORTS  = 10;

    // SHA-1 initial hash values and round constants.
    localparam logic [31:0] IV_0 = 32'h67452301;
    localparam logic [31:0] IV_1 = 32'hEFCDAB89;
    localparam logic [31:0] IV_2 = 32'h98BADCFE;
    localparam logic [31:0] IV_3 = 32'h10325476;
    localparam logic [31:0] IV_4 = 32'hC3D2E1F0;
    localparam logic [31:0] RC_CH  = 32'h5A827999;
    localparam logic [31:0] RC_PA1 = 32'h6ED9EBA1;
    localparam logic [31:0] RC_MAJ = 32'h8F1BBCDC;
    localparam logic [31:0] RC_PA2 = 32'hCA62C1D6;
    localparam logic [7:0]  PAD_FIRST = 8'h80;
    localparam int unsigned LEN_OFFSET = 56;
    localparam logic [2:0]  LAST_INDEX = 3'd4;

    typedef struct {
        logic [7:0] data;
        logic       has_byte;
        logic       eom;
    } msg_item_t;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  word_idx;
        logic        is_last;
    } digest_word_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_byte_valid = 1'b0;
    logic        i_end_of_message = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    sha1_stream_hasher_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_data_byte      (i_data_byte),
        .i_byte_valid     (i_byte_valid),
        .i_end_of_message (i_end_of_message),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_digest_word    (o_digest_word),
        .o_word_index     (o_word_index),
        .o_last_word      (o_last_word)
    );

    // Message lengths that land on or next to the padding boundaries.
    int unsigned pad_edges [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

    msg_item_t    message_items [$];
    digest_word_t digest_words_due [$];

    // Hash state of the predictor.
    logic [31:0] hash_words [5];
    logic [7:0]  block_bytes [64];
    int unsigned block_fill;
    logic [60:0] msg_length;

    int unsigned items_queued;
    int unsigned messages_queued;
    int unsigned messages_hashed;
    int unsigned bytes_hashed;
    int unsigned words_checked;
    int unsigned fail_count;
    int unsigned idle_cycles;
    logic        in_taken;

    int unsigned gap_left;
    int unsigned burst_left;
    int unsigned stall_mode;
    int unsigned stall_left;
    int unsigned stall_phase;

    // Rotate a 32-bit word left.
    function automatic logic [31:0] rotl(logic [31:0] v, int unsigned s);
        return (v << s) | (v >> (32 - s));
    endfunction

    // Return the predictor to the start of a new message.
    task automatic hash_restart();
        hash_words[0] = IV_0;
        hash_words[1] = IV_1;
        hash_words[2] = IV_2;
        hash_words[3] = IV_3;
        hash_words[4] = IV_4;
        block_fill = 0;
        msg_length = '0;
    endtask

    // Run the 80 rounds over the buffered block and fold into the hash words.
    task automatic sha_compress();
        logic [31:0] sched [16];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int r = 0; r < 16; r++) begin
            sched[r] = {block_bytes[4 * r], block_bytes[4 * r + 1],
                        block_bytes[4 * r + 2], block_bytes[4 * r + 3]};
        end
        a = hash_words[0];
        b = hash_words[1];
        c = hash_words[2];
        d = hash_words[3];
        e = hash_words[4];
        for (int r = 0; r < 80; r++) begin
            if (r >= 16) begin
                sched[r % 16] = rotl(sched[(r - 3) % 16] ^ sched[(r - 8) % 16] ^
                                     sched[(r - 14) % 16] ^ sched[r % 16], 1);
            end
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = RC_CH;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = RC_PA1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = RC_MAJ;
            end else begin
                f = b ^ c ^ d;
                k = RC_PA2;
            end
            t = rotl(a, 5) + f + e + k + sched[r % 16];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        hash_words[0] += a;
        hash_words[1] += b;
        hash_words[2] += c;
        hash_words[3] += d;
        hash_words[4] += e;
    endtask

    // Put one byte into the block, compressing when the block is full.
    task automatic block_append(logic [7:0] value);
        block_bytes[block_fill] = value;
        block_fill++;
        if (block_fill == 64) begin
            sha_compress();
            block_fill = 0;
        end
    endtask

    // Absorb one accepted input transfer; an end mark pads and queues the digest.
    task automatic hash_item(logic [7:0] data, logic has_byte, logic eom);
        logic [63:0]  bit_len;
        digest_word_t dw;
        if (has_byte) begin
            msg_length++;
            bytes_hashed++;
            block_append(data);
        end
        if (!eom) return;
        bit_len = {msg_length, 3'b000};
        block_append(PAD_FIRST);
        // No room left for the length: zero out this block and start another.
        if (block_fill > LEN_OFFSET) begin
            while (block_fill != 0) block_append(8'h00);
        end
        while (block_fill < LEN_OFFSET) block_append(8'h00);
        for (int i = 0; i < 8; i++) block_append(bit_len[63 - 8 * i -: 8]);
        for (int i = 0; i < 5; i++) begin
            dw.word = hash_words[i];
            dw.word_idx = 3'(i);
            dw.is_last = (3'(i) == LAST_INDEX);
            digest_words_due.push_back(dw);
        end
        messages_hashed++;
        hash_restart();
    endtask

    task automatic report_failure(string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS) $display("%0t ns: %s", $time, what);
    endtask

    task automatic push_item(logic [7:0] data, logic has_byte, logic eom);
        msg_item_t it;
        it.data = data;
        it.has_byte = has_byte;
        it.eom = eom;
        message_items.push_back(it);
        if (has_byte || eom) items_queued++;
        if (eom) messages_queued++;
    endtask

    // Queue a message of random bytes with some ignored items mixed in. The end
    // mark rides on the last byte or comes as an item of its own.
    task automatic push_message(int unsigned n_bytes);
        logic end_on_byte;
        end_on_byte = (n_bytes != 0) && ($urandom_range(0, 1) == 1);
        for (int unsigned i = 0; i < n_bytes; i++) begin
            if ($urandom_range(0, 11) == 0) push_item(8'($urandom), 1'b0, 1'b0);
            push_item(8'($urandom), 1'b1, end_on_byte && (i == n_bytes - 1));
        end
        if (!end_on_byte) push_item(8'($urandom), 1'b0, 1'b1);
    endtask

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Input driver: bursts of transfers separated by random gaps.
    always @(negedge i_clk) begin : drive_input
        msg_item_t nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left = 0;
            burst_left = 0;
        end else if (!i_in_valid || in_taken) begin
            if (gap_left != 0 || message_items.size() == 0) begin
                if (gap_left != 0) gap_left--;
                i_in_valid <= 1'b0;
            end else begin
                nxt = message_items.pop_front();
                i_in_valid <= 1'b1;
                i_data_byte <= nxt.data;
                i_byte_valid <= nxt.has_byte;
                i_end_of_message <= nxt.eom;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end
        end
    end

    // Output stall: modes of random length, from never stalling to mostly stalling.
    always @(negedge i_clk) begin : drive_stall
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(8, 60);
        end else begin
            stall_left--;
        end
        stall_phase++;
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 1) == 1);
            2: i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= (stall_phase % 3 == 0);
        endcase
    end

    // Monitor: check digest transfers, feed input transfers to the predictor,
    // and watch for a hang.
    always @(posedge i_clk) begin : watch_transfers
        digest_word_t want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
            idle_cycles = 0;
        end else begin
            in_taken <= i_in_valid && !o_in_stall;
            if (o_out_valid && !i_out_stall) begin
                if (digest_words_due.size() == 0) begin
                    report_failure($sformatf(
                        "unexpected digest word %08h index %0d last %0b",
                        o_digest_word, o_word_index, o_last_word));
                end else begin
                    want = digest_words_due.pop_front();
                    words_checked++;
                    if (o_digest_word !== want.word || o_word_index !== want.word_idx ||
                        o_last_word !== want.is_last) begin
                        report_failure($sformatf(
                            "digest mismatch: expected %08h index %0d last %0b, got %08h index %0d last %0b",
                            want.word, want.word_idx, want.is_last,
                            o_digest_word, o_word_index, o_last_word));
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                hash_item(i_data_byte, i_byte_valid, i_end_of_message);
            end
            if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Hang: no transfer for %0d cycles, %0d digest words pending",
                         IDLE_LIMIT, digest_words_due.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin : run_test
        int unsigned n;
        hash_restart();

        // Directed: empty message, the classic three-byte message, end mark on a
        // byte, end mark on its own, and ignored items between message bytes.
        push_item(8'h5A, 1'b0, 1'b1);
        push_item(8'h61, 1'b1, 1'b0);
        push_item(8'h62, 1'b1, 1'b0);
        push_item(8'h63, 1'b1, 1'b1);
        push_item(8'hFF, 1'b1, 1'b1);
        push_item(8'h00, 1'b1, 1'b1);
        push_item(8'hFF, 1'b0, 1'b0);
        push_item(8'h00, 1'b1, 1'b0);
        push_item(8'h00, 1'b0, 1'b0);
        push_item(8'hFF, 1'b1, 1'b0);
        push_item(8'hFF, 1'b0, 1'b1);
        push_item(8'h00, 1'b0, 1'b1);

        // Random messages: many short ones, many around the padding boundaries,
        // and some of arbitrary length.
        items_queued = 0;
        messages_queued = 0;
        while (items_queued < RANDOM_ITEMS || messages_queued < MIN_MESSAGES) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: n = $urandom_range(0, 12);
                5, 6, 7: n = pad_edges[$urandom_range(0, 7)];
                default: n = $urandom_range(1, 140);
            endcase
            push_message(n);
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (message_items.size() != 0 || i_in_valid) @(posedge i_clk);
        while (digest_words_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Hashed %0d messages with %0d message bytes in total.",
                 messages_hashed, bytes_hashed);
        $display("Checked %0d digest words, %0d failures.", words_checked, fail_count);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
